>>> rtl/core/jfrk4_pkg.sv
// Package for the jerk flow RK4 step core: item types, command and status structs,
// sequencer and multiplier state encodings, fixed field widths and defaults.
// No dependencies.
package jfrk4_pkg;

  localparam int WORD_WIDTH_DEFAULT    = 32;
  localparam int FRACTION_BITS_DEFAULT = 24;

  localparam int STEP_W    = 25;
  localparam int TIME_W    = 48;
  localparam int OUT_W     = 32;
  localparam int MUL_CHUNK = 32;

  localparam logic [STEP_W-1:0] STEP_RESET = 25'd167772;

  // Runge-Kutta stage index.
  localparam logic [1:0] STG_K1 = 2'd0;
  localparam logic [1:0] STG_K2 = 2'd1;
  localparam logic [1:0] STG_K3 = 2'd2;
  localparam logic [1:0] STG_K4 = 2'd3;

  typedef struct packed {
    logic restart;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]       time_now;
    logic signed [OUT_W-1:0] x_now;
    logic signed [OUT_W-1:0] y_now;
    logic signed [OUT_W-1:0] z_now;
  } out_item_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_size;
  } cfg_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PREP,
    ST_MA,
    ST_MA_W,
    ST_NEG,
    ST_SUBY,
    ST_SUBX,
    ST_ADD1,
    ST_MB,
    ST_MB_W,
    ST_KACC,
    ST_MC,
    ST_MC_W,
    ST_ZN,
    ST_ZN_W,
    ST_YN,
    ST_YN_W,
    ST_COMMIT,
    ST_OUT
  } ctl_state_e;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_ACC,
    MUL_RND,
    MUL_SAT
  } mul_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_PREP,
    OP_NEG,
    OP_NEG_SUM,
    OP_SUBY,
    OP_SUBX,
    OP_ADD1,
    OP_K1,
    OP_K2,
    OP_K3,
    OP_K4,
    OP_ZN,
    OP_YN,
    OP_COMMIT
  } dp_op_e;

  typedef enum logic [2:0] {
    SEL_C06_ZA,
    SEL_H_T,
    SEL_SIXTH_S,
    SEL_H_Z,
    SEL_H_Y
  } mul_sel_e;

  typedef struct packed {
    dp_op_e   op;
    mul_sel_e mul_sel;
    logic     mul_start;
    logic     load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic mul_done;
  } dp_stat_t;

endpackage

>>> rtl/core/jfrk4_stream_if.sv
// Valid/ready channel interface used for the input, result and configuration words.
// The payload type is a parameter; the item structs come from jfrk4_pkg.
interface jfrk4_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/jfrk4_mul.sv
// Shared fixed-point multiplier: sign-magnitude product built from 32x32 partial
// products, then rounded to nearest and saturated. Depends on jfrk4_pkg.
module jfrk4_mul #(
  parameter int W = jfrk4_pkg::WORD_WIDTH_DEFAULT,
  parameter int F = jfrk4_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic                done_o,
  output logic signed [W-1:0] res_o
);
  import jfrk4_pkg::*;

  localparam int CW  = MUL_CHUNK;
  localparam int NCH = (W + CW - 1) / CW;
  localparam int PW  = NCH * CW;
  localparam int AW  = 2 * PW;
  localparam int IW  = (NCH > 1) ? $clog2(NCH) : 1;

  mul_state_e state_q, state_d;

  logic [PW-1:0]       ua_q, ua_d, ub_q, ub_d;
  logic                neg_q, neg_d;
  logic [IW-1:0]       i_q, i_d, j_q, j_d;
  logic [AW-1:0]       acc_q, acc_d;
  logic signed [W-1:0] res_q, res_d;

  logic [W-1:0]    a_u, b_u, mag_a, mag_b;
  logic [2*CW-1:0] pp;
  logic [AW-1:0]   pp_sh, q, lim, qc;
  logic [W-1:0]    qw;
  logic            last;
  int unsigned     sh;

  always_comb begin
    a_u   = a_i;
    b_u   = b_i;
    mag_a = a_u[W-1] ? (~a_u + W'(1)) : a_u;
    mag_b = b_u[W-1] ? (~b_u + W'(1)) : b_u;
    pp    = ua_q[i_q*CW +: CW] * ub_q[j_q*CW +: CW];
    sh    = CW * (int'(i_q) + int'(j_q));
    pp_sh = AW'(pp) << sh;
    last  = (i_q == IW'(NCH - 1)) && (j_q == IW'(NCH - 1));
    q     = acc_q >> F;
    lim   = neg_q ? (AW'(1) << (W - 1)) : ((AW'(1) << (W - 1)) - AW'(1));
    qc    = (q > lim) ? lim : q;
    qw    = qc[W-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      MUL_IDLE: begin
        if (start_i) state_d = MUL_ACC;
      end
      MUL_ACC: begin
        if (last) state_d = MUL_RND;
      end
      MUL_RND: state_d = MUL_SAT;
      MUL_SAT: state_d = MUL_IDLE;
      default: state_d = MUL_IDLE;
    endcase
  end

  always_comb begin
    ua_d  = ua_q;
    ub_d  = ub_q;
    neg_d = neg_q;
    i_d   = i_q;
    j_d   = j_q;
    acc_d = acc_q;
    res_d = res_q;
    case (state_q)
      MUL_IDLE: begin
        if (start_i) begin
          ua_d  = PW'(mag_a);
          ub_d  = PW'(mag_b);
          neg_d = a_u[W-1] ^ b_u[W-1];
          i_d   = '0;
          j_d   = '0;
          acc_d = '0;
        end
      end
      MUL_ACC: begin
        acc_d = acc_q + pp_sh;
        if (j_q == IW'(NCH - 1)) begin
          j_d = '0;
          i_d = i_q + IW'(1);
        end else begin
          j_d = j_q + IW'(1);
        end
      end
      MUL_RND: acc_d = acc_q + (AW'(1) << (F - 1));
      // The magnitude is clamped first, so negating the negative limit gives the minimum.
      MUL_SAT: res_d = neg_q ? (~qw + W'(1)) : qw;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MUL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ua_q  <= ua_d;
    ub_q  <= ub_d;
    neg_q <= neg_d;
    i_q   <= i_d;
    j_q   <= j_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign done_o = (state_q == MUL_SAT);
  assign res_o  = res_q;

endmodule

>>> rtl/core/jfrk4_dp.sv
// Datapath of the jerk flow step: state, step size, RK temporaries, two saturating
// adders, the shared multiplier and the result register. Depends on jfrk4_pkg, jfrk4_mul.
module jfrk4_dp #(
  parameter int W = jfrk4_pkg::WORD_WIDTH_DEFAULT,
  parameter int F = jfrk4_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  jfrk4_pkg::ctl_cmd_t         cmd_i,
  output jfrk4_pkg::dp_stat_t         stat_o,
  input  logic                        cfg_we_i,
  input  logic [jfrk4_pkg::STEP_W-1:0] cfg_step_i,
  output jfrk4_pkg::out_item_t        out_data_o
);
  import jfrk4_pkg::*;

  localparam logic [65:0] RAW_ONE   = 66'd1 << F;
  localparam logic [65:0] RAW_C06   = ((66'd6 << F) + 66'd5) / 66'd10;
  localparam logic [65:0] RAW_SIXTH = (RAW_ONE + 66'd3) / 66'd6;
  localparam logic [65:0] WMAX_RAW  = (66'd1 << (W - 1)) - 66'd1;

  localparam logic signed [W-1:0] W_MAX   = WMAX_RAW[W-1:0];
  localparam logic signed [W-1:0] W_MIN   = ~W_MAX;
  localparam logic signed [W-1:0] K_ONE   = (RAW_ONE > WMAX_RAW) ? W_MAX : RAW_ONE[W-1:0];
  localparam logic signed [W-1:0] K_C06   = (RAW_C06 > WMAX_RAW) ? W_MAX : RAW_C06[W-1:0];
  localparam logic signed [W-1:0] K_SIXTH =
      (RAW_SIXTH > WMAX_RAW) ? W_MAX : RAW_SIXTH[W-1:0];
  localparam int HW = ((W > STEP_W) ? W : STEP_W) + 1;

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b,
                                                  input logic sub);
    logic [W:0] ax;
    logic [W:0] bx;
    logic [W:0] sum;
    ax  = {a[W-1], a};
    bx  = {b[W-1], b};
    sum = sub ? (ax - bx) : (ax + bx);
    if (sum[W] != sum[W-1]) begin
      return sum[W] ? W_MIN : W_MAX;
    end
    return sum[W-1:0];
  endfunction

  logic signed [W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [TIME_W-1:0]   time_q, time_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic signed [W-1:0] ax_q, ax_d, za_q, za_d, t_q, t_d, s_q, s_d, d_q, d_d;
  out_item_t           out_q, out_d;

  logic signed [W-1:0] h, mul_a, mul_b, mul_res;
  logic signed [W-1:0] a0, b0, a1, b1, sum0, sum1;
  logic                sub0, sub1, mul_done;
  logic [HW-1:0]       step_ext, wmax_ext;
  logic signed [63:0]  xe, ye, ze;

  // The step size beyond the word range is clamped before it enters a product.
  always_comb begin
    step_ext = HW'(step_q);
    wmax_ext = (HW'(1) << (W - 1)) - HW'(1);
    h        = (step_ext > wmax_ext) ? W_MAX : W'(step_q);
  end

  always_comb begin
    mul_a = h;
    mul_b = t_q;
    case (cmd_i.mul_sel)
      SEL_C06_ZA: begin
        mul_a = K_C06;
        mul_b = za_q;
      end
      SEL_H_T: begin
        mul_a = h;
        mul_b = t_q;
      end
      SEL_SIXTH_S: begin
        mul_a = K_SIXTH;
        mul_b = s_q;
      end
      SEL_H_Z: begin
        mul_a = h;
        mul_b = z_q;
      end
      SEL_H_Y: begin
        mul_a = h;
        mul_b = y_q;
      end
      default: ;
    endcase
  end

  jfrk4_mul #(
    .W(W),
    .F(F)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  always_comb begin
    a0   = '0;
    b0   = '0;
    sub0 = 1'b0;
    a1   = '0;
    b1   = '0;
    sub1 = 1'b0;
    case (cmd_i.op)
      OP_PREP: begin
        b0   = x_q;
        sub0 = 1'b1;
      end
      OP_NEG: begin
        b0   = mul_res;
        sub0 = 1'b1;
      end
      OP_NEG_SUM: begin
        b0   = mul_res;
        sub0 = 1'b1;
        a1   = s_q;
        b1   = d_q;
      end
      OP_SUBY: begin
        a0   = t_q;
        b0   = y_q;
        sub0 = 1'b1;
      end
      OP_SUBX: begin
        a0   = t_q;
        b0   = ax_q;
        sub0 = 1'b1;
      end
      OP_ADD1: begin
        a0 = t_q;
        b0 = K_ONE;
      end
      OP_K1, OP_K2: begin
        a0 = z_q;
        b0 = mul_res >>> 1;
        a1 = mul_res;
        b1 = mul_res;
      end
      OP_K3: begin
        a0 = z_q;
        b0 = mul_res;
        a1 = mul_res;
        b1 = mul_res;
      end
      OP_K4: begin
        a1 = s_q;
        b1 = mul_res;
      end
      OP_ZN: begin
        a0 = z_q;
        b0 = mul_res;
      end
      OP_YN: begin
        a0 = y_q;
        b0 = mul_res;
      end
      OP_COMMIT: begin
        a0 = x_q;
        b0 = mul_res;
      end
      default: ;
    endcase
    sum0 = sat_add(a0, b0, sub0);
    sum1 = sat_add(a1, b1, sub1);
  end

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    time_d = time_q;
    step_d = step_q;
    ax_d   = ax_q;
    za_d   = za_q;
    t_d    = t_q;
    s_d    = s_q;
    d_d    = d_q;
    out_d  = out_q;
    xe     = 64'(x_q);
    ye     = 64'(y_q);
    ze     = 64'(z_q);
    case (cmd_i.op)
      OP_CLEAR: begin
        x_d    = '0;
        y_d    = '0;
        z_d    = '0;
        time_d = '0;
      end
      OP_PREP: begin
        ax_d = x_q[W-1] ? sum0 : x_q;
        za_d = z_q;
      end
      OP_NEG, OP_SUBY, OP_SUBX, OP_ADD1, OP_YN: t_d = sum0;
      // The doubled k of the previous stage joins the sum while this stage starts.
      OP_NEG_SUM: begin
        t_d = sum0;
        s_d = sum1;
      end
      OP_K1: begin
        za_d = sum0;
        s_d  = mul_res;
      end
      OP_K2, OP_K3: begin
        za_d = sum0;
        d_d  = sum1;
      end
      OP_K4: s_d = sum1;
      OP_ZN: za_d = sum0;
      OP_COMMIT: begin
        x_d    = sum0;
        y_d    = t_q;
        z_d    = za_q;
        time_d = time_q + TIME_W'(step_q);
      end
      default: ;
    endcase
    if (cfg_we_i) step_d = cfg_step_i;
    if (cmd_i.load_out) begin
      out_d.time_now = time_q;
      out_d.x_now    = xe[OUT_W-1:0];
      out_d.y_now    = ye[OUT_W-1:0];
      out_d.z_now    = ze[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      time_q <= '0;
      step_q <= STEP_RESET;
    end else begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      time_q <= time_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q  <= ax_d;
    za_q  <= za_d;
    t_q   <= t_d;
    s_q   <= s_d;
    d_q   <= d_d;
    out_q <= out_d;
  end

  assign stat_o.mul_done = mul_done;
  assign out_data_o      = out_q;

endmodule

>>> rtl/core/jfrk4_ctl.sv
// Sequencer of the jerk flow step: walks the four RK stages and the Euler updates
// over the datapath and owns the input and result handshakes. Depends on jfrk4_pkg.
module jfrk4_ctl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_restart_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jfrk4_pkg::ctl_cmd_t cmd_o,
  input  jfrk4_pkg::dp_stat_t stat_i
);
  import jfrk4_pkg::*;

  ctl_state_e state_q, state_d;
  logic [1:0] stage_q, stage_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    stage_d       = stage_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    in_ready_o    = 1'b0;
    cmd_o.op        = OP_NONE;
    cmd_o.mul_sel   = SEL_H_T;
    cmd_o.mul_start = 1'b0;
    cmd_o.load_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = in_restart_i ? ST_CLEAR : ST_PREP;
      end
      ST_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        state_d  = ST_OUT;
      end
      ST_PREP: begin
        cmd_o.op = OP_PREP;
        stage_d  = STG_K1;
        state_d  = ST_MA;
      end
      ST_MA: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = SEL_C06_ZA;
        state_d         = ST_MA_W;
      end
      ST_MA_W: begin
        if (stat_i.mul_done) state_d = ST_NEG;
      end
      ST_NEG: begin
        cmd_o.op = (stage_q == STG_K3 || stage_q == STG_K4) ? OP_NEG_SUM : OP_NEG;
        state_d  = ST_SUBY;
      end
      ST_SUBY: begin
        cmd_o.op = OP_SUBY;
        state_d  = ST_SUBX;
      end
      ST_SUBX: begin
        cmd_o.op = OP_SUBX;
        state_d  = ST_ADD1;
      end
      ST_ADD1: begin
        cmd_o.op = OP_ADD1;
        state_d  = ST_MB;
      end
      ST_MB: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = SEL_H_T;
        state_d         = ST_MB_W;
      end
      ST_MB_W: begin
        if (stat_i.mul_done) state_d = ST_KACC;
      end
      ST_KACC: begin
        case (stage_q)
          STG_K1:  cmd_o.op = OP_K1;
          STG_K2:  cmd_o.op = OP_K2;
          STG_K3:  cmd_o.op = OP_K3;
          default: cmd_o.op = OP_K4;
        endcase
        if (stage_q == STG_K4) begin
          state_d = ST_MC;
        end else begin
          stage_d = stage_q + 2'd1;
          state_d = ST_MA;
        end
      end
      ST_MC: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = SEL_SIXTH_S;
        state_d         = ST_MC_W;
      end
      ST_MC_W: begin
        if (stat_i.mul_done) state_d = ST_ZN;
      end
      // The Euler products read the old y and z, so they start alongside the adds.
      ST_ZN: begin
        cmd_o.op        = OP_ZN;
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = SEL_H_Z;
        state_d         = ST_ZN_W;
      end
      ST_ZN_W: begin
        if (stat_i.mul_done) state_d = ST_YN;
      end
      ST_YN: begin
        cmd_o.op        = OP_YN;
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = SEL_H_Y;
        state_d         = ST_YN_W;
      end
      ST_YN_W: begin
        if (stat_i.mul_done) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.op = OP_COMMIT;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= STG_K1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/jerk_flow_rk4_step_core.sv
// Top level of the jerk flow RK4 step core: sequencer plus datapath behind three
// valid/ready channels. Depends on jfrk4_pkg, jfrk4_stream_if, jfrk4_ctl, jfrk4_dp.

// Each input word either restarts the flow (time, x, y and z go to zero) or advances it by
// one step of size h, taken from the step_size register (unsigned, FRACTION_BITS fraction
// bits, reset value about 0.01), and each gives exactly one result word with the new time,
// x, y and z. A step runs through one shared multiplier eleven times (two per RK stage,
// three for the final updates). A new word is accepted only once the previous result has
// been loaded into the output register. The result sits in an output register, so a new
// word is taken while the previous result waits. Write step_size only while the core is
// idle; cfg_i is always ready.
module jerk_flow_rk4_step_core #(
  parameter int WORD_WIDTH    = jfrk4_pkg::WORD_WIDTH_DEFAULT,
  parameter int FRACTION_BITS = jfrk4_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  jfrk4_stream_if.sink          in_i,
  jfrk4_stream_if.source        out_o,
  jfrk4_stream_if.sink          cfg_i
);
  import jfrk4_pkg::*;

  ctl_cmd_t  cmd;
  dp_stat_t  stat;
  out_item_t out_data;
  logic      in_ready;
  logic      out_valid;

  jfrk4_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_restart_i(in_i.data.restart),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  jfrk4_dp #(
    .W(WORD_WIDTH),
    .F(FRACTION_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .cfg_we_i  (cfg_i.valid),
    .cfg_step_i(cfg_i.data.step_size),
    .out_data_o(out_data)
  );

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

`ifndef SYNTH
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_i.valid && in_i.ready && in_i.data.restart) |=> (cmd.op == OP_CLEAR))
    else $error("restart word did not clear the state");

  a_step_prepares: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_i.valid && in_i.ready && !in_i.data.restart) |=> (cmd.op == OP_PREP))
    else $error("step word did not start the RK sequence");

  a_mul_idle_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
      stat.mul_done |-> !in_i.ready)
    else $error("multiplier finished while the core was taking input");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd.load_out |-> (!out_o.valid || out_o.ready))
    else $error("pending result overwritten");
`endif

endmodule

>>> verif/jerk_flow_rk4_step_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for jerk_flow_rk4_step_core: directed and random restart/step words
// with random idling on both channels, checked against a fixed-point flow predictor.
// Depends on jfrk4_pkg, jfrk4_stream_if and the core itself.
module jerk_flow_rk4_step_core_tb;
  import jfrk4_pkg::*;

  localparam int STEP_LATENCY = 68;
  localparam int HOLD_CYCLES  = 600;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_WORDS = 1300;

  localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};
  localparam logic [STEP_W-1:0] STEP_ONE = 25'h1000000;

  // Q8.24 constants of the flow.
  localparam longint Q_MAX       = 64'sd2147483647;
  localparam longint Q_MIN       = -Q_MAX - 1;
  localparam longint Q_ONE       = 64'sd1 << 24;
  localparam longint Q_POINT_SIX = ((64'sd6 << 24) + 5) / 10;
  localparam longint Q_SIXTH     = (Q_ONE + 3) / 6;

  localparam out_item_t CLEARED = '0;

  typedef struct packed {
    bit                set_step;
    logic [STEP_W-1:0] step;
    bit                restart;
    bit                known;
    out_item_t         result;
  } probe_t;

  // Rows: set_step, step, restart, known, result.
  probe_t directed_probes [0:22] = '{
    '{1'b0, 25'd0, 1'b1, 1'b1, CLEARED},      // restart straight after reset
    '{1'b0, 25'd0, 1'b0, 1'b0, CLEARED},      // steps with the reset step size
    '{1'b0, 25'd0, 1'b0, 1'b0, CLEARED},
    '{1'b0, 25'd0, 1'b0, 1'b0, CLEARED},
    '{1'b0, 25'd0, 1'b1, 1'b1, CLEARED},
    '{1'b1, 25'd0, 1'b0, 1'b1, CLEARED},      // a zero step leaves the cleared state alone
    '{1'b0, 25'd0, 1'b0, 1'b1, CLEARED},
    '{1'b1, 25'd1, 1'b0, 1'b0, CLEARED},      // smallest nonzero step
    '{1'b0, 25'd0, 1'b0, 1'b0, CLEARED},
    '{1'b1, STEP_MAX, 1'b0, 1'b0, CLEARED},   // step just under two, drives toward saturation
    '{1'b0, 25'd0, 1'b0, 1'b0, CLEARED},
    '{1'b0, 25'd0, 1'b0, 1'b0, CLEARED},
    '{1'b0, 25'd0, 1'b0, 1'b0, CLEARED},
    '{1'b0, 25'd0, 1'b0, 1'b0, CLEARED},
    '{1'b0, 25'd0, 1'b1, 1'b1, CLEARED},
    '{1'b1, STEP_ONE, 1'b0, 1'b0, CLEARED},   // step of exactly one
    '{1'b0, 25'd0, 1'b0, 1'b0, CLEARED},
    '{1'b0, 25'd0, 1'b0, 1'b0, CLEARED},
    '{1'b0, 25'd0, 1'b0, 1'b0, CLEARED},
    '{1'b0, 25'd0, 1'b1, 1'b1, CLEARED},
    '{1'b0, 25'd0, 1'b1, 1'b1, CLEARED},      // back-to-back restarts
    '{1'b1, STEP_RESET, 1'b0, 1'b0, CLEARED},
    '{1'b0, 25'd0, 1'b0, 1'b0, CLEARED}
  };

  logic clk_i;
  logic rst_ni;

  jfrk4_stream_if #(.payload_t(in_item_t))  in_if ();
  jfrk4_stream_if #(.payload_t(out_item_t)) out_if ();
  jfrk4_stream_if #(.payload_t(cfg_item_t)) cfg_if ();

  jerk_flow_rk4_step_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Predictor state, advanced once per accepted input word.
  longint            flow_x;
  longint            flow_y;
  longint            flow_z;
  logic [TIME_W-1:0] flow_time;
  logic [STEP_W-1:0] step_shadow;

  out_item_t expected_q [$];
  int        mismatches;
  int        results_seen;
  int        idle_count;
  bit        hold_req;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic longint clamp_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // Product rounded to nearest on the magnitude, ties away from zero, then saturated.
  function automatic longint qmul(longint a, longint b);
    bit                neg;
    longint unsigned   ua;
    longint unsigned   ub;
    longint unsigned   q;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? longint'(-a) : a;
    ub  = (b < 0) ? longint'(-b) : b;
    q   = (ua * ub + (64'd1 << 23)) >> 24;
    if (q > (neg ? 64'd2147483648 : 64'd2147483647)) return neg ? Q_MIN : Q_MAX;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint jerk_dz(longint z, longint x, longint y);
    longint t;
    t = clamp_q(0 - qmul(Q_POINT_SIX, z));
    t = clamp_q(t - y);
    t = clamp_q(t - ((x < 0) ? clamp_q(0 - x) : x));
    return clamp_q(t + Q_ONE);
  endfunction

  function automatic out_item_t advance_flow(bit restart);
    longint    h;
    longint    k1;
    longint    k2;
    longint    k3;
    longint    k4;
    longint    rk_sum;
    out_item_t r;
    if (restart) begin
      flow_x    = 0;
      flow_y    = 0;
      flow_z    = 0;
      flow_time = '0;
    end else begin
      h  = longint'(step_shadow);
      // Stage halving is a floor division, so an arithmetic shift.
      k1 = qmul(h, jerk_dz(flow_z, flow_x, flow_y));
      k2 = qmul(h, jerk_dz(clamp_q(flow_z + (k1 >>> 1)), flow_x, flow_y));
      k3 = qmul(h, jerk_dz(clamp_q(flow_z + (k2 >>> 1)), flow_x, flow_y));
      k4 = qmul(h, jerk_dz(clamp_q(flow_z + k3), flow_x, flow_y));
      rk_sum = clamp_q(clamp_q(clamp_q(k1 + clamp_q(k2 + k2)) + clamp_q(k3 + k3)) + k4);
      // y and x use the old z and y.
      flow_x    = clamp_q(flow_x + qmul(h, flow_y));
      flow_y    = clamp_q(flow_y + qmul(h, flow_z));
      flow_z    = clamp_q(flow_z + qmul(Q_SIXTH, rk_sum));
      flow_time = flow_time + TIME_W'(step_shadow);
    end
    r.time_now = flow_time;
    r.x_now    = flow_x[OUT_W-1:0];
    r.y_now    = flow_y[OUT_W-1:0];
    r.z_now    = flow_z[OUT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result word %0d: %s expected %h, got %h", results_seen, field, want, got);
    end
  endfunction

  task automatic send_word(input bit restart, input bit known, input out_item_t typed);
    out_item_t predicted;
    @(negedge clk_i);
    in_if.valid        <= 1'b1;
    in_if.data.restart <= restart;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = advance_flow(restart);
    expected_q.push_back(known ? typed : predicted);
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_step(input logic [STEP_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid          <= 1'b1;
    cfg_if.data.step_size <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    step_shadow = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %p", out_if.data);
      end else begin
        want = expected_q.pop_front();
        check_field("time_now", 64'(out_if.data.time_now), 64'(want.time_now));
        check_field("x_now", 64'(out_if.data.x_now), 64'(want.x_now));
        check_field("y_now", 64'(out_if.data.y_now), 64'(want.y_now));
        check_field("z_now", 64'(out_if.data.z_now), 64'(want.z_now));
      end
      results_seen++;
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_count <= 0;
    end else if (idle_count >= STALL_LIMIT) begin
      $display("** jerk_flow_rk4_step_core: FAILED **");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Result receiver: stretches of always ready, random ready and mostly stalled, plus
  // one long hold-off on request.
  initial begin : receiver
    int mode;
    int stretch;
    out_if.ready = 1'b0;
    forever begin
      mode    = $urandom_range(0, 2);
      stretch = $urandom_range(10, 200);
      repeat (stretch) begin
        @(negedge clk_i);
        if (hold_req) begin
          hold_req = 1'b0;
          out_if.ready <= 1'b0;
          repeat (HOLD_CYCLES - 1) begin
            @(negedge clk_i);
            out_if.ready <= 1'b0;
          end
        end else begin
          case (mode)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= 1'($urandom_range(0, 1));
            default: out_if.ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    int                rand_sent;
    int                phase;
    int                phase_len;
    int                burst_left;
    int                gap_max;
    logic [STEP_W-1:0] h_pick;
    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.data            = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.data.step_size = STEP_RESET;
    flow_x                = 0;
    flow_y                = 0;
    flow_z                = 0;
    flow_time             = '0;
    step_shadow           = STEP_RESET;
    mismatches            = 0;
    results_seen          = 0;
    idle_count            = 0;
    hold_req              = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_probes[i]) begin
      if (directed_probes[i].set_step) begin
        wait_all_results();
        write_step(directed_probes[i].step);
      end
      send_word(directed_probes[i].restart, directed_probes[i].known,
                directed_probes[i].result);
    end

    // Random phases; each starts from an idle core with a new step size.
    rand_sent = 0;
    phase     = 0;
    while (rand_sent < RANDOM_WORDS) begin
      wait_all_results();
      case ($urandom_range(0, 9))
        0:       h_pick = '0;
        1:       h_pick = 25'd1;
        2:       h_pick = STEP_MAX;
        3:       h_pick = STEP_ONE;
        4:       h_pick = STEP_RESET;
        5, 6:    h_pick = STEP_W'($urandom());
        default: h_pick = STEP_W'($urandom_range(1, 1 << 22));
      endcase
      write_step(h_pick);
      phase_len = $urandom_range(10, 120);
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      // One phase keeps offering words while the receiver holds off, so the core backs up.
      if (phase == 2) begin
        hold_req = 1'b1;
        gap_max  = 0;
      end
      burst_left = 0;
      for (int i = 0; i < phase_len; i++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          if (gap_max > 0) begin
            repeat ($urandom_range(1, gap_max)) begin
              @(negedge clk_i);
              in_if.valid <= 1'b0;
            end
          end
        end
        burst_left--;
        send_word((i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0),
                  1'b0, CLEARED);
        rand_sent++;
      end
      phase++;
    end

    wait_all_results();
    repeat (2 * STEP_LATENCY) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("** jerk_flow_rk4_step_core: PASSED **");
    end else begin
      $display("** jerk_flow_rk4_step_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/jfrk4_pkg.sv
rtl/core/jfrk4_stream_if.sv
rtl/core/jfrk4_mul.sv
rtl/core/jfrk4_dp.sv
rtl/core/jfrk4_ctl.sv
rtl/core/jerk_flow_rk4_step_core.sv
verif/jerk_flow_rk4_step_core_tb.sv
